### rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the MIDI stream parser: result kinds, sysex
// phase codes, register indexes, status byte codes and the identifier and result structs.
// ----------------------------------------------------------------------------
package msp_pkg;

   // result kind codes
   typedef enum logic [2:0] {
      KIND_REALTIME = 3'd0,
      KIND_CHANNEL  = 3'd1,
      KIND_PARAM    = 3'd2,
      KIND_COMMIT   = 3'd3,
      KIND_ERROR    = 3'd4
   } msp_kind_type;

   // sysex parsing phases
   typedef enum logic [3:0] {
      PH_NONE   = 4'd0,
      PH_IGNORE = 4'd1,
      PH_ID0    = 4'd2,
      PH_ID1    = 4'd3,
      PH_ID2    = 4'd4,
      PH_PARAMH = 4'd5,
      PH_PARAML = 4'd6,
      PH_VALUEH = 4'd7,
      PH_VALUEL = 4'd8
   } msp_phase_type;

   // configuration register indexes
   localparam logic [1:0] CSR_ID_FIRST  = 2'd0;
   localparam logic [1:0] CSR_ID_SECOND = 2'd1;
   localparam logic [1:0] CSR_ID_THIRD  = 2'd2;

   // system bytes
   localparam logic [7:0] SYS_SYSEX_START = 8'hF0;
   localparam logic [7:0] SYS_MTC_QF      = 8'hF1;
   localparam logic [7:0] SYS_SONG_POS    = 8'hF2;
   localparam logic [7:0] SYS_SONG_SEL    = 8'hF3;
   localparam logic [7:0] SYS_SYSEX_END   = 8'hF7;
   localparam logic [7:0] RT_CLOCK        = 8'hF8;
   localparam logic [7:0] RT_START        = 8'hFA;
   localparam logic [7:0] RT_CONTINUE     = 8'hFB;
   localparam logic [7:0] RT_STOP         = 8'hFC;

   // channel message high nibbles
   localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
   localparam logic [3:0] NIB_CTRL      = 4'hB;
   localparam logic [3:0] NIB_PROGRAM   = 4'hC;
   localparam logic [3:0] NIB_PRESSURE  = 4'hD;
   localparam logic [3:0] NIB_BEND      = 4'hE;
   localparam logic [3:0] NIB_SYSTEM    = 4'hF;

   // sysex identifier configuration
   typedef struct packed {
      logic [6:0] first;
      logic [6:0] second;
      logic [6:0] third;
   } msp_id_type;

   // one result transaction
   typedef struct packed {
      msp_kind_type kind;
      logic [7:0]   status_byte;
      logic [6:0]   data_first;
      logic [6:0]   data_second;
      logic [6:0]   param_high;
      logic [6:0]   param_low;
      logic [6:0]   value_high;
      logic [6:0]   value_low;
   } msp_result_type;

endpackage

### rtl/core/msp_if.sv
// ----------------------------------------------------------------------------
// msp channel interfaces
// Valid/ready channels of the MIDI stream parser: input byte, result and
// configuration write.
// ----------------------------------------------------------------------------

// input byte channel
interface msp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

// result channel
interface msp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] status_byte;
   logic [6:0] data_first;
   logic [6:0] data_second;
   logic [6:0] param_high;
   logic [6:0] param_low;
   logic [6:0] value_high;
   logic [6:0] value_low;

   modport source (output valid, output kind, output status_byte, output data_first,
                   output data_second, output param_high, output param_low,
                   output value_high, output value_low, input ready);
   modport sink (input valid, input kind, input status_byte, input data_first,
                 input data_second, input param_high, input param_low,
                 input value_high, input value_low, output ready);
endinterface

// configuration write channel
interface msp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [6:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/midi_stream_parser_sysex_params_core.sv
// ----------------------------------------------------------------------------
// midi_stream_parser_sysex_params_core
// MIDI byte stream parser with running status and sysex parameter loading.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received MIDI byte per transaction. rsp_chan carries
//   zero or one result per byte: realtime clock codes, completed channel
//   messages but program change, sysex parameter writes, sysex commit and error.
//   csr_chan writes the three sysex identifier bytes (index 0, 1, 2); other
//   indexes are dropped. Write these only while no byte is in flight.
// Path: a byte is loaded into the input register on its accepting edge, and
//   its result is loaded into the result register when the parser step
//   takes that byte.
// Throughput: one byte per cycle while rsp_chan does not stall; the input
//   register and the result register each hold one transaction.
// Reset: clears running status, counts, data bytes, sysex phase, held sysex
//   bytes and the identifier registers; both channels come up empty.
// Stall: while a result waits on rsp_chan, one more byte is taken into the
//   input register; after that req_chan.ready stays low until the result
//   is taken, and bytes without a result drain only once the slot frees.
// ----------------------------------------------------------------------------
module midi_stream_parser_sysex_params_core
   import msp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   msp_req_if.sink    req_chan,
   msp_rsp_if.source  rsp_chan,
   msp_csr_if.sink    csr_chan
);

   msp_id_type sysex_id;

   // identifier registers
   msp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .sysex_id (sysex_id)
   );

   // parser datapath
   msp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .sysex_id (sysex_id),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/core/msp_csr_regs.sv
// ----------------------------------------------------------------------------
// msp_csr_regs
// Sysex identifier registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module msp_csr_regs
   import msp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   msp_csr_if.sink      csr_chan,
   output msp_id_type   sysex_id
);

   msp_id_type id_ff;
   msp_id_type id_in;
   logic       wr_fire;

   // writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr_fire        = csr_chan.valid;

   // register decode, indexes past the list are dropped
   always_comb begin
      id_in = id_ff;
      if (wr_fire) begin
         case (csr_chan.index)
            CSR_ID_FIRST:  id_in.first  = csr_chan.data;
            CSR_ID_SECOND: id_in.second = csr_chan.data;
            CSR_ID_THIRD:  id_in.third  = csr_chan.data;
            default:       id_in = id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= '0;
      end else begin
         id_ff <= id_in;
      end
   end

   assign sysex_id = id_ff;

endmodule

### rtl/core/msp_parse.sv
// ----------------------------------------------------------------------------
// msp_parse
// Input byte register, parser state with running status and sysex phase,
// and the result register toward the result channel.
// ----------------------------------------------------------------------------
module msp_parse
   import msp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  msp_id_type   sysex_id,
   msp_req_if.sink      req_chan,
   msp_rsp_if.source    rsp_chan
);

   // input stage
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     byte_ff, byte_in_nxt;

   // parser state
   logic [7:0]     running_status_ff, running_status_in;
   logic [1:0]     needed_count_ff, needed_count_in;
   logic [1:0]     received_count_ff, received_count_in;
   logic [6:0]     data0_ff, data0_in;
   logic [6:0]     data1_ff, data1_in;
   msp_phase_type  phase_ff, phase_in;
   logic [6:0]     held_ph_ff, held_ph_in;
   logic [6:0]     held_pl_ff, held_pl_in;
   logic [6:0]     held_vh_ff, held_vh_in;

   // result stage
   logic           out_valid_ff, out_valid_in;
   msp_result_type out_ff, out_in;

   logic           req_fire;
   logic           take;
   logic           res_valid;
   msp_result_type res;
   logic [1:0]     cnt_next;
   logic [3:0]     nib;

   // handshake: process the held byte when the result slot is free or draining
   assign take           = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // input register next value
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in_nxt = byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         byte_in_nxt = req_chan.byte_in;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   assign cnt_next = received_count_ff + 2'd1;
   assign nib      = running_status_ff[7:4];

   // parser step on the held byte
   always_comb begin
      running_status_in = running_status_ff;
      needed_count_in   = needed_count_ff;
      received_count_in = received_count_ff;
      data0_in          = data0_ff;
      data1_in          = data1_ff;
      phase_in          = phase_ff;
      held_ph_in        = held_ph_ff;
      held_pl_in        = held_pl_ff;
      held_vh_in        = held_vh_ff;
      res               = '0;
      res_valid         = 1'b0;
      if (take) begin
         if (byte_ff[7:4] == NIB_SYSTEM) begin
            // system bytes
            case (byte_ff)
               RT_CLOCK, RT_START, RT_CONTINUE, RT_STOP: begin
                  res_valid       = 1'b1;
                  res.kind        = KIND_REALTIME;
                  res.status_byte = byte_ff;
               end
               SYS_MTC_QF, SYS_SONG_POS, SYS_SONG_SEL: begin
                  received_count_in = 2'd0;
                  running_status_in = byte_ff;
                  needed_count_in   = (byte_ff == SYS_SONG_POS) ? 2'd2 : 2'd1;
               end
               SYS_SYSEX_START: begin
                  phase_in = PH_ID0;
               end
               SYS_SYSEX_END: begin
                  phase_in = PH_NONE;
                  if (phase_ff == PH_PARAMH) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_COMMIT;
                  end else if (phase_ff != PH_NONE && phase_ff != PH_IGNORE) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_ERROR;
                  end
               end
               default: begin
                  res_valid = 1'b0;
               end
            endcase
         end else if (byte_ff[7]) begin
            // channel status byte, also ends sysex
            phase_in          = PH_NONE;
            received_count_in = 2'd0;
            running_status_in = byte_ff;
            needed_count_in   = (byte_ff[7:4] == NIB_PROGRAM ||
                                 byte_ff[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
         end else begin
            // data byte
            case (phase_ff)
               PH_ID0: phase_in = (byte_ff[6:0] == sysex_id.first)  ? PH_ID1 : PH_IGNORE;
               PH_ID1: phase_in = (byte_ff[6:0] == sysex_id.second) ? PH_ID2 : PH_IGNORE;
               PH_ID2: phase_in = (byte_ff[6:0] == sysex_id.third) ? PH_PARAMH : PH_IGNORE;
               PH_PARAMH: begin
                  held_ph_in = byte_ff[6:0];
                  phase_in   = PH_PARAML;
               end
               PH_PARAML: begin
                  held_pl_in = byte_ff[6:0];
                  phase_in   = PH_VALUEH;
               end
               PH_VALUEH: begin
                  held_vh_in = byte_ff[6:0];
                  phase_in   = PH_VALUEL;
               end
               PH_VALUEL: begin
                  phase_in       = PH_PARAMH;
                  res_valid      = 1'b1;
                  res.kind       = KIND_PARAM;
                  res.param_high = held_ph_ff;
                  res.param_low  = held_pl_ff;
                  res.value_high = held_vh_ff;
                  res.value_low  = byte_ff[6:0];
               end
               PH_NONE: begin
                  if (running_status_ff != 8'd0) begin
                     if (received_count_ff[0]) begin
                        data1_in = byte_ff[6:0];
                     end else begin
                        data0_in = byte_ff[6:0];
                     end
                     if (cnt_next < needed_count_ff) begin
                        received_count_in = cnt_next;
                     end else begin
                        received_count_in = 2'd0;
                        if (nib == NIB_NOTE_OFF || nib == NIB_NOTE_ON || nib == NIB_BEND ||
                            nib == NIB_CTRL || nib == NIB_PRESSURE) begin
                           res_valid       = 1'b1;
                           res.kind        = KIND_CHANNEL;
                           res.status_byte = running_status_ff;
                           res.data_first  = data0_in;
                           res.data_second = data1_in;
                        end
                     end
                  end
               end
               default: begin
                  res_valid = 1'b0;
               end
            endcase
         end
      end
   end

   // result register next value
   always_comb begin
      out_in = out_ff;
      if (take) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_in = res;
         end
      end else begin
         out_valid_in = out_valid_ff && !rsp_chan.ready;
      end
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         running_status_ff <= 8'd0;
         needed_count_ff   <= 2'd0;
         received_count_ff <= 2'd0;
         data0_ff          <= 7'd0;
         data1_ff          <= 7'd0;
         phase_ff          <= PH_NONE;
         held_ph_ff        <= 7'd0;
         held_pl_ff        <= 7'd0;
         held_vh_ff        <= 7'd0;
      end else begin
         in_valid_ff       <= in_valid_in;
         out_valid_ff      <= out_valid_in;
         running_status_ff <= running_status_in;
         needed_count_ff   <= needed_count_in;
         received_count_ff <= received_count_in;
         data0_ff          <= data0_in;
         data1_ff          <= data1_in;
         phase_ff          <= phase_in;
         held_ph_ff        <= held_ph_in;
         held_pl_ff        <= held_pl_in;
         held_vh_ff        <= held_vh_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in_nxt;
      out_ff  <= out_in;
   end

   // result channel
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_ff.kind;
   assign rsp_chan.status_byte = out_ff.status_byte;
   assign rsp_chan.data_first  = out_ff.data_first;
   assign rsp_chan.data_second = out_ff.data_second;
   assign rsp_chan.param_high  = out_ff.param_high;
   assign rsp_chan.param_low   = out_ff.param_low;
   assign rsp_chan.value_high  = out_ff.value_high;
   assign rsp_chan.value_low   = out_ff.value_low;

   // byte count stays below the needed count, or is zero
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (received_count_ff < needed_count_ff) || (received_count_ff == 2'd0))
      else $error("received count out of range");

   // running status is either empty or a status byte
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      (running_status_ff == 8'd0) || running_status_ff[7])
      else $error("running status holds a data byte");

   // a parameter write returns the sysex phase to parameter high
   a_param_phase: assert property (@(posedge clock) disable iff (reset)
      (take && res_valid && res.kind == KIND_PARAM) |=> (phase_ff == PH_PARAMH))
      else $error("phase not rewound after parameter write");

   // sysex end results leave the block outside sysex
   a_end_phase: assert property (@(posedge clock) disable iff (reset)
      (take && res_valid && (res.kind == KIND_COMMIT || res.kind == KIND_ERROR))
      |=> (phase_ff == PH_NONE))
      else $error("phase not cleared at sysex end");

   // a held result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !take)
      else $error("result slot overwritten under stall");

endmodule

### verif/tb_midi_stream_parser_sysex_params_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_stream_parser_sysex_params_core
// Self-checking bench for the MIDI stream parser. A scoreboard object tracks
// running status, data bytes and the sysex phase for every accepted byte and
// queues the result it expects; each result taken from the block is checked
// field by field against the oldest entry. Directed bytes cover the special
// cases, then weighted random traffic of well-formed channel, system-common
// and mostly well-formed sysex messages mixed with noise runs under several
// identifier settings, random idle bursts on both channels, one long result stall.
// ----------------------------------------------------------------------------

// scoreboard: parser state model plus queue of pending results
class midi_parse_scoreboard;
   msp_pkg::msp_id_type     ids;
   logic [7:0]              run_status;
   logic [1:0]              need_cnt;
   logic [1:0]              got_cnt;
   logic [6:0]              data_byte [2];
   msp_pkg::msp_phase_type  phase;
   logic [6:0]              hold_param_hi;
   logic [6:0]              hold_param_lo;
   logic [6:0]              hold_value_hi;
   msp_pkg::msp_result_type pending_results [$];
   int unsigned             mismatch_count;

   function new();
      ids            = '0;
      run_status     = '0;
      need_cnt       = '0;
      got_cnt        = '0;
      data_byte[0]   = '0;
      data_byte[1]   = '0;
      phase          = msp_pkg::PH_NONE;
      hold_param_hi  = '0;
      hold_param_lo  = '0;
      hold_value_hi  = '0;
      mismatch_count = 0;
   endfunction

   function void report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endfunction

   function void write_id(logic [1:0] idx, logic [6:0] val);
      case (idx)
         msp_pkg::CSR_ID_FIRST:  ids.first  = val;
         msp_pkg::CSR_ID_SECOND: ids.second = val;
         msp_pkg::CSR_ID_THIRD:  ids.third  = val;
         default: ;
      endcase
   endfunction

   // advance the parser model by one accepted byte transaction
   function void predict_byte(logic [7:0] b);
      msp_pkg::msp_result_type r;
      bit                      has_result;
      logic [3:0]              hi;
      logic [3:0]              st_hi;
      r          = '0;
      has_result = 1'b0;
      hi         = b[7:4];
      if (hi == msp_pkg::NIB_SYSTEM) begin
         case (b)
            msp_pkg::RT_CLOCK, msp_pkg::RT_START,
            msp_pkg::RT_CONTINUE, msp_pkg::RT_STOP: begin
               r.kind        = msp_pkg::KIND_REALTIME;
               r.status_byte = b;
               has_result    = 1'b1;
            end
            msp_pkg::SYS_MTC_QF, msp_pkg::SYS_SONG_POS, msp_pkg::SYS_SONG_SEL: begin
               got_cnt    = '0;
               run_status = b;
               need_cnt   = (b == msp_pkg::SYS_SONG_POS) ? 2'd2 : 2'd1;
            end
            msp_pkg::SYS_SYSEX_START: phase = msp_pkg::PH_ID0;
            msp_pkg::SYS_SYSEX_END: begin
               if (phase == msp_pkg::PH_PARAMH) begin
                  r.kind     = msp_pkg::KIND_COMMIT;
                  has_result = 1'b1;
               end else if (phase != msp_pkg::PH_NONE && phase != msp_pkg::PH_IGNORE) begin
                  r.kind     = msp_pkg::KIND_ERROR;
                  has_result = 1'b1;
               end
               phase = msp_pkg::PH_NONE;
            end
            default: ;
         endcase
      end else if (b[7]) begin
         // channel status ends any sysex block
         phase      = msp_pkg::PH_NONE;
         got_cnt    = '0;
         run_status = b;
         need_cnt   = (hi == msp_pkg::NIB_PROGRAM || hi == msp_pkg::NIB_PRESSURE) ?
                      2'd1 : 2'd2;
      end else begin
         case (phase)
            msp_pkg::PH_ID0:
               phase = (b[6:0] == ids.first) ? msp_pkg::PH_ID1 : msp_pkg::PH_IGNORE;
            msp_pkg::PH_ID1:
               phase = (b[6:0] == ids.second) ? msp_pkg::PH_ID2 : msp_pkg::PH_IGNORE;
            msp_pkg::PH_ID2:
               phase = (b[6:0] == ids.third) ? msp_pkg::PH_PARAMH : msp_pkg::PH_IGNORE;
            msp_pkg::PH_PARAMH: begin
               hold_param_hi = b[6:0];
               phase         = msp_pkg::PH_PARAML;
            end
            msp_pkg::PH_PARAML: begin
               hold_param_lo = b[6:0];
               phase         = msp_pkg::PH_VALUEH;
            end
            msp_pkg::PH_VALUEH: begin
               hold_value_hi = b[6:0];
               phase         = msp_pkg::PH_VALUEL;
            end
            msp_pkg::PH_VALUEL: begin
               phase        = msp_pkg::PH_PARAMH;
               r.kind       = msp_pkg::KIND_PARAM;
               r.param_high = hold_param_hi;
               r.param_low  = hold_param_lo;
               r.value_high = hold_value_hi;
               r.value_low  = b[6:0];
               has_result   = 1'b1;
            end
            msp_pkg::PH_NONE: begin
               // data bytes with running status; dropped while no status
               if (run_status != 8'd0) begin
                  data_byte[got_cnt[0]] = b[6:0];
                  got_cnt = got_cnt + 2'd1;
                  if (got_cnt >= need_cnt) begin
                     got_cnt = '0;
                     st_hi   = run_status[7:4];
                     if (st_hi == msp_pkg::NIB_NOTE_OFF || st_hi == msp_pkg::NIB_NOTE_ON ||
                         st_hi == msp_pkg::NIB_BEND || st_hi == msp_pkg::NIB_CTRL ||
                         st_hi == msp_pkg::NIB_PRESSURE) begin
                        r.kind        = msp_pkg::KIND_CHANNEL;
                        r.status_byte = run_status;
                        r.data_first  = data_byte[0];
                        r.data_second = data_byte[1];
                        has_result    = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (has_result) pending_results.push_back(r);
   endfunction

   function void check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
   endfunction

   // compare one accepted result transaction with the oldest expectation
   function void check_result(msp_pkg::msp_result_type got);
      msp_pkg::msp_result_type want;
      if (pending_results.size() == 0) begin
         report($sformatf("unexpected result kind %0d status %0h", got.kind, got.status_byte));
         return;
      end
      want = pending_results.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("status_byte", got.status_byte, want.status_byte);
      check_field("data_first", got.data_first, want.data_first);
      check_field("data_second", got.data_second, want.data_second);
      check_field("param_high", got.param_high, want.param_high);
      check_field("param_low", got.param_low, want.param_low);
      check_field("value_high", got.value_high, want.value_high);
      check_field("value_low", got.value_low, want.value_low);
   endfunction

   function void flush_leftover();
      while (pending_results.size() != 0) begin
         report($sformatf("result never arrived, kind %0d", pending_results[0].kind));
         void'(pending_results.pop_front());
      end
   endfunction
endclass

module tb_midi_stream_parser_sysex_params_core;
   import msp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned LONG_HOLD    = 400;

   // codes the package does not name
   localparam logic [1:0] CSR_UNUSED    = 2'd3;
   localparam logic [7:0] SYS_UNDEF_F4  = 8'hF4;
   localparam logic [7:0] SYS_RESET_ALL = 8'hFF;

   logic clock;
   logic reset;

   msp_req_if req_bus ();
   msp_rsp_if rsp_bus ();
   msp_csr_if csr_bus ();

   midi_stream_parser_sysex_params_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   midi_parse_scoreboard parser_sb = new();

   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;
   int unsigned gap_odds    = 8;
   int unsigned stall_odds  = 8;
   bit          quiet       = 1'b0;
   bit          hold_request = 1'b0;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL midi_stream_parser_sysex_params_core");
         $finish;
      end
   end

   // result side: check transactions, drive ready with random stalls
   initial begin
      msp_result_type got;
      int unsigned    hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind        = msp_kind_type'(rsp_bus.kind);
            got.status_byte = rsp_bus.status_byte;
            got.data_first  = rsp_bus.data_first;
            got.data_second = rsp_bus.data_second;
            got.param_high  = rsp_bus.param_high;
            got.param_low   = rsp_bus.param_low;
            got.value_high  = rsp_bus.value_high;
            got.value_low   = rsp_bus.value_low;
            parser_sb.check_result(got);
         end
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, stall_odds) == 0) begin
            hold_left = $urandom_range(1, 17) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one byte transaction, with an optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(0, gap_odds) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.byte_in <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parser_sb.predict_byte(b);
      items_sent++;
   endtask

   function automatic logic [7:0] pick_realtime();
      case ($urandom_range(0, 3))
         0: return RT_CLOCK;
         1: return RT_START;
         2: return RT_CONTINUE;
         default: return RT_STOP;
      endcase
   endfunction

   // data byte, sometimes preceded by an interleaved realtime byte
   task automatic send_data(input logic [6:0] d);
      if ($urandom_range(0, 15) == 0) send_byte(pick_realtime());
      send_byte({1'b0, d});
   endtask

   function automatic logic [6:0] rand_data();
      case ($urandom_range(0, 7))
         0: return 7'h00;
         1: return 7'h7F;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      parser_sb.write_id(idx, val);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_ids(input logic [6:0] a, input logic [6:0] b, input logic [6:0] c);
      write_csr(CSR_ID_FIRST, a);
      write_csr(CSR_ID_SECOND, b);
      write_csr(CSR_ID_THIRD, c);
   endtask

   // stop offering, wait for all results, then let the input register drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (parser_sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // channel message, with running status where the last status allows
   task automatic send_channel_msg(input bit force_status);
      logic [7:0] st;
      int         n;
      st = parser_sb.run_status;
      if (force_status || st == 8'd0 || st[7:4] == NIB_SYSTEM ||
          $urandom_range(0, 2) != 0) begin
         st = 8'($urandom_range({NIB_NOTE_OFF, 4'h0}, {NIB_BEND, 4'hF}));
         send_byte(st);
      end
      n = (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 1 : 2;
      for (int i = 0; i < n; i++) send_data(rand_data());
   endtask

   task automatic send_common();
      case ($urandom_range(0, 2))
         0: begin
            send_byte(SYS_MTC_QF);
            send_data(rand_data());
         end
         1: begin
            send_byte(SYS_SONG_SEL);
            send_data(rand_data());
         end
         default: begin
            send_byte(SYS_SONG_POS);
            send_data(rand_data());
            send_data(rand_data());
         end
      endcase
   endtask

   // sysex block: mostly well formed, sometimes broken or mismatched
   task automatic send_sysex();
      int unsigned mode;
      int unsigned bad_pos;
      int unsigned id_len;
      logic [6:0]  id_byte [3];
      mode    = $urandom_range(0, 11);
      id_byte[0] = parser_sb.ids.first;
      id_byte[1] = parser_sb.ids.second;
      id_byte[2] = parser_sb.ids.third;
      bad_pos = $urandom_range(0, 2);
      if (mode == 0) id_byte[bad_pos] = id_byte[bad_pos] ^ 7'($urandom_range(1, 127));
      id_len  = (mode == 1) ? $urandom_range(0, 2) : 3;
      send_byte(SYS_SYSEX_START);
      for (int i = 0; i < id_len; i++) send_data(id_byte[i]);
      if (mode != 1) begin
         repeat ($urandom_range(0, 3)) begin
            repeat (4) send_data(rand_data());
         end
      end
      case (mode)
         2: begin
            // truncated parameter group
            repeat ($urandom_range(1, 3)) send_data(rand_data());
            send_byte(SYS_SYSEX_END);
         end
         3: send_channel_msg(1'b1);
         4: ;
         default: send_byte(SYS_SYSEX_END);
      endcase
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned start;
      int unsigned pick;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) send_sysex();
         else if (pick < 70) send_channel_msg(1'b0);
         else if (pick < 76) send_common();
         else if (pick < 90) send_byte(8'($urandom_range(0, 255)));
         else send_byte(pick_realtime());
      end
   endtask

   task automatic new_idle_odds();
      gap_odds   = $urandom_range(1, 30);
      stall_odds = $urandom_range(1, 30);
   endtask

   // main sequence
   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.byte_in <= 8'd0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_ID_FIRST;
      csr_bus.data    <= 7'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: realtime, ignored system bytes, running status, stale data
      send_byte(8'h45);
      send_byte(RT_CLOCK);
      send_byte(RT_START);
      send_byte(RT_CONTINUE);
      send_byte(RT_STOP);
      send_byte(SYS_UNDEF_F4);
      send_byte(SYS_RESET_ALL);
      send_byte({NIB_NOTE_ON, 4'h0});
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte({NIB_PRESSURE, 4'h5});
      send_byte(8'h7F);
      send_byte({NIB_PROGRAM, 4'h3});
      send_byte(8'h12);
      send_byte(SYS_SONG_POS);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte({NIB_BEND, 4'hF});
      send_byte(8'h7F);
      send_byte(8'h7F);
      wait_idle();

      // directed sysex: parameter write and commit, short block error, id mismatch
      set_ids(7'h7F, 7'h00, 7'h55);
      write_csr(CSR_UNUSED, 7'h2A);
      send_byte(SYS_SYSEX_START);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(8'h55);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      send_byte(8'h7F);
      send_byte(SYS_SYSEX_END);
      send_byte(SYS_SYSEX_START);
      send_byte(8'h7F);
      send_byte(SYS_SYSEX_END);
      send_byte(SYS_SYSEX_START);
      send_byte(8'h01);
      send_byte(SYS_SYSEX_END);
      wait_idle();

      // random phases over several identifier settings
      set_ids(7'h7F, 7'h7F, 7'h7F);
      new_idle_odds();
      run_random(420);
      wait_idle();

      set_ids(7'h00, 7'h00, 7'h00);
      new_idle_odds();
      hold_request = 1'b1;
      run_random(420);
      wait_idle();

      set_ids(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
      new_idle_odds();
      run_random(420);
      wait_idle();

      set_ids(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
      new_idle_odds();
      run_random(220);
      quiet = 1'b1;
      run_random(220);

      wait_idle();
      parser_sb.flush_leftover();
      if (parser_sb.mismatch_count == 0) begin
         $display("PASS midi_stream_parser_sysex_params_core");
      end else begin
         $display("FAIL midi_stream_parser_sysex_params_core");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/msp_pkg.sv
rtl/core/msp_if.sv
rtl/core/msp_csr_regs.sv
rtl/core/msp_parse.sv
rtl/core/midi_stream_parser_sysex_params_core.sv
verif/tb_midi_stream_parser_sysex_params_core.sv
